/* rtl/pid_pkg.sv */
// ----------------------------------------------------------------------------
// pid_pkg: shared types and constants for the PID position step
// Microcode word layout, the program table, widths and saturation helpers.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int COUNT_W_DEF = 16;
  localparam int COUNT_W_MAX = 32;

  localparam int GAIN_W = 16;
  localparam int POS_W  = 16;
  localparam int ERR_W  = 17;
  localparam int PREV_W = 18;
  localparam int SUM_W  = 32;
  localparam int DRV_W  = 32;

  // shared multiplier: 17-bit signed by 33-bit signed
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = COUNT_W_MAX + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W - 8;

  localparam logic [MUL_A_W-1:0] SCALE_Q16   = 17'd60495;
  localparam logic [POS_W-1:0]   TARGET_RST  = 16'd50;
  localparam logic signed [ERR_W-1:0] ERR_MAX = 17'sd65535;
  localparam logic signed [ERR_W-1:0] ERR_MIN = -17'sd65535;

  // configuration register indexes
  localparam int CFG_AW = 2;
  typedef enum logic [CFG_AW-1:0] {
    REG_PROP_GAIN   = 2'd0,
    REG_INTEG_GAIN  = 2'd1,
    REG_DERIV_GAIN  = 2'd2,
    REG_TARGET_POS  = 2'd3
  } cfg_reg_e;

  // sequencer program
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SCALE = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ERR   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MULP  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MULI  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_MULD  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_ACCD  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_WB    = 3'd7;

  typedef enum logic [1:0] {
    MUL_SCALE = 2'd0,
    MUL_PROP  = 2'd1,
    MUL_INTEG = 2'd2,
    MUL_DERIV = 2'd3
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_CLR  = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_NO_IN    = 2'd1,
    COND_OUT_BUSY = 2'd2
  } cond_e;

  typedef struct packed {
    mul_sel_e          mul_sel;
    logic              mul_en;
    logic              err_ld;
    acc_op_e           acc_op;
    logic              wb;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // control store; falling through the last step wraps to STEP_WAIT
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{mul_sel: MUL_SCALE, mul_en: 1'b0, err_ld: 1'b0, acc_op: ACC_HOLD,
          wb: 1'b0, cond: COND_NONE, target: STEP_WAIT};
    unique case (step)
      STEP_WAIT: begin
        c.cond   = COND_NO_IN;
        c.target = STEP_WAIT;
      end
      STEP_SCALE: begin
        c.mul_sel = MUL_SCALE;
        c.mul_en  = 1'b1;
      end
      STEP_ERR: begin
        c.err_ld = 1'b1;
      end
      STEP_MULP: begin
        c.mul_sel = MUL_PROP;
        c.mul_en  = 1'b1;
        c.acc_op  = ACC_CLR;
      end
      STEP_MULI: begin
        c.mul_sel = MUL_INTEG;
        c.mul_en  = 1'b1;
        c.acc_op  = ACC_ADD;
      end
      STEP_MULD: begin
        c.mul_sel = MUL_DERIV;
        c.mul_en  = 1'b1;
        c.acc_op  = ACC_ADD;
      end
      STEP_ACCD: begin
        c.acc_op = ACC_ADD;
      end
      STEP_WB: begin
        c.wb     = 1'b1;
        c.cond   = COND_OUT_BUSY;
        c.target = STEP_WB;
      end
      default: begin
        c.cond   = COND_NONE;
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [DRV_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32'sh7fffffff);
    lo = ACC_W'(32'sh80000000);
    if (x > hi)      return 32'sh7fffffff;
    else if (x < lo) return 32'sh80000000;
    else             return x[DRV_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W+1:0] x);
    logic signed [SUM_W+1:0] hi;
    logic signed [SUM_W+1:0] lo;
    hi = 34'sd2147483647;
    lo = -34'sd2147483648;
    if (x > hi)      return 32'sh7fffffff;
    else if (x < lo) return 32'sh80000000;
    else             return x[SUM_W-1:0];
  endfunction

endpackage

/* rtl/pid_position_step.sv */
// ----------------------------------------------------------------------------
// pid_position_step: discrete PID position controller, one tick per word
// Microcoded sequencer around one shared signed multiplier and accumulator.
// ----------------------------------------------------------------------------
// Program (8 steps): an accepted word runs scale, error, P, I, D, accumulate
//   and write-back; the next word is taken only at the wait step. The single
//   shared multiplier is used four times per tick (scale, P, I, D).
// Output register holds a finished word while the next input is accepted;
//   the write-back step waits only if that register is still occupied.
// Reset: asynchronous, active low; gains 0, target 50, error sum and last
//   error 0, sequencer at its wait step, no result pending.
module pid_position_step #(
  parameter int COUNT_WIDTH = pid_pkg::COUNT_W_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [pid_pkg::CFG_AW-1:0]        cfg_addr_i,
  input  logic [15:0]                       cfg_wdata_i,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [COUNT_WIDTH-1:0]            encoder_count_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pid_pkg::DRV_W-1:0]  drive_value_o,
  output logic signed [pid_pkg::ERR_W-1:0]  position_error_o,
  output logic                              sum_saturated_o
);
  import pid_pkg::*;

  // configuration registers
  logic signed [GAIN_W-1:0] prop_q, integ_q, deriv_q;
  logic [POS_W-1:0]         target_q;

  // controller state
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [PREV_W-1:0] prev_q;

  // sequencer
  logic [STEP_W-1:0] pc_q, pc_d;
  ctrl_t             cw;
  logic              jump;

  // datapath
  logic [COUNT_WIDTH-1:0]    count_q;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic signed [PREV_W-1:0]  diff;
  logic [SUM_W-1:0]          scaled;
  logic signed [SUM_W+1:0]   err_wide;
  logic signed [SUM_W+1:0]   sum_wide;
  logic                      hit;

  // output register
  logic                      out_valid_q;
  logic signed [DRV_W-1:0]   drive_q;
  logic signed [ERR_W-1:0]   perr_q;
  logic                      sat_q;

  logic in_fire, out_busy, wb_fire;

  assign cw       = ucode(pc_q);
  assign in_ready_o = (pc_q == STEP_WAIT);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_busy = out_valid_q && !out_ready_i;
  assign wb_fire  = cw.wb && !out_busy;

  // ---------------- step counter with conditional jumps ----------------
  always_comb begin
    unique case (cw.cond)
      COND_NONE:     jump = 1'b0;
      COND_NO_IN:    jump = !in_valid_i;
      COND_OUT_BUSY: jump = out_busy;
      default:       jump = 1'b0;
    endcase
    pc_d = jump ? cw.target : pc_q + 1'b1;
  end

  // ---------------- shared multiplier operand select ----------------
  assign diff = PREV_W'(err_q) - prev_q;

  always_comb begin
    unique case (cw.mul_sel)
      MUL_SCALE: begin
        mul_a = $signed(SCALE_Q16);
        mul_b = $signed({1'b0, COUNT_W_MAX'(count_q)});
      end
      MUL_PROP: begin
        mul_a = MUL_A_W'(prop_q);
        mul_b = MUL_B_W'(err_q);
      end
      MUL_INTEG: begin
        mul_a = MUL_A_W'(integ_q);
        mul_b = MUL_B_W'(sum_q);
      end
      MUL_DERIV: begin
        mul_a = MUL_A_W'(deriv_q);
        mul_b = MUL_B_W'(diff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // ---------------- error: target minus scaled count, clamped ----------------
  // scale product is count * 12/13 in Q16; drop the fraction
  assign scaled   = prod_q[SUM_W+15:16];
  assign err_wide = $signed({18'd0, target_q}) - $signed({2'd0, scaled});

  always_comb begin
    if (err_wide > (SUM_W+2)'(ERR_MAX))      err_d = ERR_MAX;
    else if (err_wide < (SUM_W+2)'(ERR_MIN)) err_d = ERR_MIN;
    else                                     err_d = err_wide[ERR_W-1:0];
  end

  // ---------------- error sum update ----------------
  assign sum_wide = (SUM_W+2)'(sum_q) + (SUM_W+2)'(err_q);
  assign sum_d    = sat_sum(sum_wide);
  assign hit      = (sum_d == 32'sh7fffffff) || (sum_d == 32'sh80000000);

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_WAIT;
      out_valid_q <= 1'b0;
      prop_q      <= '0;
      integ_q     <= '0;
      deriv_q     <= '0;
      target_q    <= TARGET_RST;
      sum_q       <= '0;
      prev_q      <= '0;
    end else begin
      pc_q <= pc_d;
      if (wb_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_addr_i))
          REG_PROP_GAIN:  prop_q   <= $signed(cfg_wdata_i);
          REG_INTEG_GAIN: integ_q  <= $signed(cfg_wdata_i);
          REG_DERIV_GAIN: deriv_q  <= $signed(cfg_wdata_i);
          REG_TARGET_POS: target_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (wb_fire) begin
        sum_q  <= sum_d;
        prev_q <= PREV_W'(err_q);
      end
    end
  end

  // ---------------- datapath registers (no reset) ----------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      count_q <= encoder_count_i;
    end
    if (cw.mul_en) begin
      prod_q <= prod_d;
    end
    if (cw.err_ld) begin
      err_q <= err_d;
    end
    unique case (cw.acc_op)
      ACC_HOLD: acc_q <= acc_q;
      ACC_CLR:  acc_q <= '0;
      ACC_ADD:  acc_q <= acc_q + prod_q[PROD_W-1:8];  // floor shift by 8
      default:  acc_q <= acc_q;
    endcase
    if (wb_fire) begin
      drive_q <= sat_acc(acc_q);
      perr_q  <= err_q;
      sat_q   <= hit;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_value_o    = drive_q;
  assign position_error_o = perr_q;
  assign sum_saturated_o  = sat_q;

  // ---------------- assertions ----------------
  // an accepted word starts the program at the scale step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (pc_q == STEP_SCALE))
    else $error("sequencer did not start after accept");

  // write-back never overwrites a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_fire |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

  // last error tracks the error just delivered
  a_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_fire |=> (prev_q == PREV_W'(position_error_o)))
    else $error("last error not updated");

  // error stays inside its clamp
  a_err_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (position_error_o != -17'sd65536))
    else $error("error out of range");

endmodule

/* test/tb_pid_position_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_position_step: self-checking bench for the PID position step
// Drives encoder counts over valid/ready, predicts every result word from a
// local fixed-point loop model and checks them in order. Covers reset values,
// gain and target corners, random ticks with idle bursts, output back-pressure
// and a tail of back-to-back words with strong gains that push the drive hard.
// ----------------------------------------------------------------------------
module tb_pid_position_step;
  import pid_pkg::*;

  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 30;

  // one predicted result word
  typedef struct {
    logic signed [DRV_W-1:0] drive;
    logic signed [ERR_W-1:0] err;
    logic                    sum_hit;
  } tick_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [15:0] encoder_count_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DRV_W-1:0] drive_value_o;
  logic signed [ERR_W-1:0] position_error_o;
  logic sum_saturated_o;

  // loop model: settings and state as the block should hold them
  logic signed [15:0] kp_q = '0;
  logic signed [15:0] ki_q = '0;
  logic signed [15:0] kd_q = '0;
  logic [15:0] target_q = TARGET_RST;
  logic signed [SUM_W-1:0] err_sum_q = '0;
  logic signed [PREV_W-1:0] prev_err_q = '0;

  tick_result_t expected_ticks[$];

  // flow control knobs shared by the tests and the result sink
  bit tx_gaps_on = 1'b0;
  bit rx_gaps_on = 1'b0;
  bit long_hold_req = 1'b0;

  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned sum_limit_words = 0;
  int unsigned drive_limit_words = 0;

  pid_position_step u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .encoder_count_i  (encoder_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_value_o    (drive_value_o),
    .position_error_o (position_error_o),
    .sum_saturated_o  (sum_saturated_o)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Loop model
  // --------------------------------------------------------------------------

  function automatic longint clamp32(input longint x);
    if (x > I32_MAX) return I32_MAX;
    if (x < I32_MIN) return I32_MIN;
    return x;
  endfunction

  // one control tick: returns the result word and advances sum / last error
  function automatic tick_result_t advance_loop(input logic [15:0] cnt);
    longint scaled, err, p_term, i_term, d_term, total, next_sum;
    tick_result_t r;
    // 12/13 as Q0.16 (rounded constant), product truncated
    scaled = (longint'(cnt) * longint'(SCALE_Q16)) >>> 16;
    err = longint'(target_q) - scaled;
    if (err > ERR_MAX) err = ERR_MAX;
    if (err < ERR_MIN) err = ERR_MIN;
    // Q8.8 gains; arithmetic shift gives the floor
    p_term = (longint'(kp_q) * err) >>> 8;
    // integral term sees the sum from before this tick
    i_term = (longint'(ki_q) * longint'(err_sum_q)) >>> 8;
    d_term = (longint'(kd_q) * (err - longint'(prev_err_q))) >>> 8;
    total = clamp32(p_term + i_term + d_term);
    next_sum = clamp32(longint'(err_sum_q) + err);
    r.drive = total[DRV_W-1:0];
    r.err = err[ERR_W-1:0];
    r.sum_hit = (next_sum == I32_MAX) || (next_sum == I32_MIN);
    err_sum_q = next_sum[SUM_W-1:0];
    prev_err_q = err[PREV_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Offer one count and wait for it to be taken. Valid stays high after the
  // handshake so back-to-back words never toggle it within one step.
  task automatic send_count(input logic [15:0] cnt);
    int unsigned gap;
    gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    encoder_count_i <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    expected_ticks.push_back(advance_loop(cnt));
  endtask

  // Drop valid and let every outstanding result come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Write all four registers, one per cycle; only called with the block idle.
  task automatic load_settings(input logic signed [15:0] p, input logic signed [15:0] i,
                               input logic signed [15:0] d, input logic [15:0] tgt);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= REG_PROP_GAIN;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    kp_q = p;
    cfg_addr_i <= REG_INTEG_GAIN;
    cfg_wdata_i <= i;
    @(posedge clk_i);
    ki_q = i;
    cfg_addr_i <= REG_DERIV_GAIN;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    kd_q = d;
    cfg_addr_i <= REG_TARGET_POS;
    cfg_wdata_i <= tgt;
    @(posedge clk_i);
    target_q = tgt;
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stall bursts, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: in-order compare against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : result_check
    tick_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_checked++;
      if (sum_saturated_o) sum_limit_words++;
      if (drive_value_o == 32'sh7fffffff || drive_value_o == 32'sh80000000)
        drive_limit_words++;
      if (expected_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result word, expected none, actual drive %0d err %0d",
                   $time, drive_value_o, position_error_o);
      end else begin
        want = expected_ticks.pop_front();
        if (drive_value_o !== want.drive)
          flag_mismatch("drive_value", want.drive, drive_value_o);
        if (position_error_o !== want.err)
          flag_mismatch("position_error", want.err, position_error_o);
        if (sum_saturated_o !== want.sum_hit)
          flag_mismatch("sum_saturated", want.sum_hit, sum_saturated_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Zero gains and target 50 straight out of reset: drive 0, err 50 - scaled.
  task automatic test_reset_defaults();
    send_count(16'd0);
    send_count(16'hFFFF);
    send_count(16'd54);
    send_count(16'd55);
    wait_drained();
  endtask

  // Gain extremes of both signs, target at both ends, count corners.
  task automatic test_directed_corners();
    load_settings(16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'hFFFF);
    send_count(16'd0);
    send_count(16'hFFFF);
    send_count(16'h5555);
    send_count(16'hAAAA);
    send_count(16'd1);
    wait_drained();
    load_settings(-16'sh8000, 16'sh7FFF, -16'sh8000, 16'd0);
    send_count(16'hFFFF);
    send_count(16'd0);
    send_count(16'h8000);
    send_count(16'h7FFF);
    wait_drained();
    // unity P, tiny I and D, counts straddling the target
    load_settings(16'sd256, 16'sd1, -16'sd1, 16'd1000);
    send_count(16'd1083);
    send_count(16'd1084);
    send_count(16'd1085);
    send_count(16'd0);
    send_count(16'd1084);
    wait_drained();
  endtask

  function automatic logic [15:0] pick_count();
    int c;
    case ($urandom_range(0, 4))
      0: c = $urandom_range(0, 65535);
      // just around the count that lands on the target
      1: begin
        c = int'(target_q) * 13 / 12 + $urandom_range(0, 8) - 4;
        if (c < 0) c = 0;
        if (c > 65535) c = 65535;
      end
      2: c = $urandom_range(0, 1) ? 65535 : 0;
      3: c = $urandom_range(0, 1) ? (1 << $urandom_range(0, 15))
                                  : (16'hFFFF ^ (1 << $urandom_range(0, 15)));
      default: c = $urandom_range(0, 255);
    endcase
    return c[15:0];
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 1024)) - 512);
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(0, 512));
    endcase
  endfunction

  // Eight settings phases, random counts, idle bursts switched per phase.
  task automatic test_random_ticks();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_settings(-16'sh8000, -16'sh8000, -16'sh8000, 16'hFFFF);
        1: load_settings(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd0);
        default: load_settings(pick_gain(), pick_gain(), pick_gain(),
                               $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 400)));
      endcase
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      repeat (212) send_count(pick_count());
      wait_drained();
    end
  endtask

  // Hold the output for a long stretch while counts keep coming, so the
  // result register fills and the input side has to stall.
  task automatic test_output_backpressure();
    load_settings(16'sd300, -16'sd20, 16'sd700, 16'd2000);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    long_hold_req = 1'b1;
    repeat (12) send_count(pick_count());
    while (long_hold_req) @(posedge clk_i);
    wait_drained();
  endtask

  // Full-scale gains, error at its upper clamp then far negative, words back to back.
  // No idling here: this is the tail of the run.
  task automatic test_tail_strong_gains();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    load_settings(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    repeat (20) send_count(16'd0);
    wait_drained();
    load_settings(-16'sh8000, -16'sh8000, 16'sh7FFF, 16'd0);
    repeat (20) send_count(16'hFFFF);
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_corners();
    test_random_ticks();
    test_output_backpressure();
    test_tail_strong_gains();
    wait_drained();
    $display("checked %0d result words over corner, random, back-pressure and strong-gain runs",
             words_checked);
    $display("error sum at a limit in %0d words, drive at a limit in %0d words",
             sum_limit_words, drive_limit_words);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("tb_pid_position_step: clean");
    end else begin
      $display("tb_pid_position_step: errors");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #200000000;
    $display("timeout with %0d result words outstanding", expected_ticks.size());
    $display("tb_pid_position_step: errors");
    $finish;
  end

endmodule
